/* hw/rtl/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the pure pursuit steering unit
// Table depth, CORDIC angle table, fixed-point constants and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  localparam int WaypointDepth = 1024;
  localparam int IdxW          = $clog2(WaypointDepth);
  localparam int CntW          = IdxW + 1;
  localparam int GoalIdxW      = 10;

  localparam int CordicIters = 24;
  localparam int IterW       = 5;
  localparam int DataW       = 64;   // CORDIC x/y datapath
  localparam int AngW        = 34;   // Q.29 angle with headroom

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 96;
  localparam int CFG_DW    = 24;
  localparam int WB_W      = 20;
  localparam int LA_W      = 24;

  localparam logic signed [AngW-1:0] PiQ29      = 34'sd1686629713;
  localparam logic signed [AngW-1:0] HalfPiQ29  = 34'sd843314857;
  localparam logic signed [AngW-1:0] AlphaLimit = 34'sd837518623;
  localparam logic signed [DataW-1:0] InvGainQ30 = 64'sd652032874;

  localparam logic [CntW-1:0] DepthCount = CntW'(WaypointDepth);

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_POSE   = 1'b1
  } op_e;

  typedef enum logic {
    REG_WHEELBASE = 1'b0,
    REG_LOOKAHEAD = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_LOAD,
    ST_ROT,
    ST_VPREP,
    ST_VEC,
    ST_SQX,
    ST_SQY,
    ST_SQD,
    ST_CHECK,
    ST_SPREP,
    ST_SMUL,
    ST_SVPREP,
    ST_GRD,
    ST_OUT
  } state_e;

  // arctangent of 2^-i in Q.29
  function automatic logic signed [AngW-1:0] atan_q29(input logic [IterW-1:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      5'd0:    r = 34'sd421657428;
      5'd1:    r = 34'sd248918915;
      5'd2:    r = 34'sd131521918;
      5'd3:    r = 34'sd66762579;
      5'd4:    r = 34'sd33510843;
      5'd5:    r = 34'sd16771758;
      5'd6:    r = 34'sd8387925;
      5'd7:    r = 34'sd4194219;
      5'd8:    r = 34'sd2097141;
      5'd9:    r = 34'sd1048575;
      5'd10:   r = 34'sd524288;
      5'd11:   r = 34'sd262144;
      5'd12:   r = 34'sd131072;
      5'd13:   r = 34'sd65536;
      5'd14:   r = 34'sd32768;
      5'd15:   r = 34'sd16384;
      5'd16:   r = 34'sd8192;
      5'd17:   r = 34'sd4096;
      5'd18:   r = 34'sd2048;
      5'd19:   r = 34'sd1024;
      5'd20:   r = 34'sd512;
      5'd21:   r = 34'sd256;
      5'd22:   r = 34'sd128;
      5'd23:   r = 34'sd64;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q.29 angle to Q3.13, rounded half up
  function automatic logic signed [15:0] q29_to_q13(input logic signed [AngW-1:0] a);
    logic signed [AngW:0] s;
    s = {{1{a[AngW-1]}}, a} + (AngW+1)'(32768);
    return 16'(s >>> 16);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pure_pursuit_steering_unit.sv */
// ----------------------------------------------------------------------------
// pure_pursuit_steering_unit: pure pursuit steering with a waypoint table
// Stores waypoints, scans them on each pose and answers a steering angle.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items: tuser = operation (0 append, 1 pose), tdata = x, y,
//   yaw. An append stores one waypoint (dropped when the table is full) and
//   gives no result. A pose gives one result on m_axis: steering, goal x/y,
//   goal index in tdata and the empty-table flag in tuser.
//   Configuration (wheelbase, lookahead) is to be written through cfg_we_i
//   only while the unit is idle; the unit itself does not enforce this.
// Operation:
//   An append is stored as it is accepted. A pose scans from the current
//   target: each waypoint takes a memory read, load, 24 rotation steps, fold,
//   24 vectoring steps on the one shared CORDIC unit, three multiplier steps
//   for the distance test and a check; the last two multiplier steps are
//   skipped when the coarse compare settles the distance, the vectoring for
//   a zero local offset. The steering then runs on the same CORDIC unit; an
//   empty table answers without a scan. One item is in flight at a time;
//   s_axis_tready is low while a pose is worked on.
// Reset clears count, target and last heading error and sets the config
// defaults; table contents are undefined until written. A stalled receiver
// holds the result in the output register; the unit waits to load the next.
// ----------------------------------------------------------------------------
`default_nettype none

module pure_pursuit_steering_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // x[31:0], y[63:32], yaw[79:64]
  input  wire logic [pps_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // operation[0]
  input  wire logic                          s_axis_tuser,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // steering_out[15:0], goal_x[47:16], goal_y[79:48], goal_index[89:80]
  output logic [pps_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // table_empty[0]
  output logic                               m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [pps_pkg::CFG_DW-1:0]    cfg_data_i
);
  import pps_pkg::*;

  state_e state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic steer_q, steer_d, flip_q, flip_d, big_q, big_d, empty_q, empty_d;
  logic [IdxW-1:0] idx_q, idx_d, tgt_q, tgt_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic signed [15:0] lhe_q, lhe_d, str_q, str_d;
  logic signed [DataW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [AngW-1:0] cz_q, cz_d, th_q, th_d;
  logic signed [32:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [31:0] px_q, px_d, py_q, py_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [WB_W-1:0] wb_q;
  logic [LA_W-1:0] la_q;
  logic [M_TDATA_W-1:0] otd_q, otd_d;
  logic ous_q, ous_d, mval_q, mval_d;

  // waypoint table
  logic [63:0] mem [WaypointDepth];
  logic [63:0] rd_q;
  logic [IdxW-1:0] rd_addr;
  logic wr_en;

  logic s_fire;
  logic signed [DataW-1:0] xs, ys;
  logic signed [AngW-1:0] at;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [32:0] ax, ay;
  logic signed [AngW-1:0] yaw_neg;
  logic signed [32:0] dxn, dyn;
  logic signed [DataW-1:0] lx, ly;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = otd_q;
  assign m_axis_tuser  = ous_q;
  assign m_axis_tvalid = mval_q;
  assign wr_en   = s_fire && (op_e'(s_axis_tuser) == OP_APPEND) && (cnt_q < DepthCount);
  assign rd_addr = (state_q == ST_GRD || state_q == ST_OUT) ? tgt_q : idx_q;

  // shared CORDIC step and multiplier
  assign xs   = cx_q >>> iter_q;
  assign ys   = cy_q >>> iter_q;
  assign at   = atan_q29(iter_q);
  assign prod = mul_a * mul_b;
  assign ax   = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign ay   = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
  assign yaw_neg = -(AngW'(signed'(s_axis_tdata[79:64])) <<< 16);
  assign dxn  = 33'(signed'(rd_q[31:0])) - 33'(px_q);
  assign dyn  = 33'(signed'(rd_q[63:32])) - 33'(py_q);
  assign lx   = DataW'(dxn) <<< 24;
  assign ly   = DataW'(dyn) <<< 24;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IdxW-1:0]] <= s_axis_tdata[63:0];
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    steer_d = steer_q;
    flip_d  = flip_q;
    big_d   = big_q;
    empty_d = empty_q;
    idx_d   = idx_q;
    tgt_d   = tgt_q;
    cnt_d   = cnt_q;
    lhe_d   = lhe_q;
    str_d   = str_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cz_d    = cz_q;
    th_d    = th_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    px_d    = px_q;
    py_d    = py_q;
    acc_d   = acc_q;
    otd_d   = otd_q;
    ous_d   = ous_q;
    mval_d  = mval_q && !m_axis_tready;
    mul_a   = '0;
    mul_b   = '0;

    case (state_q)
      // take an item: append or start a pose
      ST_IDLE: begin
        if (s_fire) begin
          if (op_e'(s_axis_tuser) == OP_APPEND) begin
            if (cnt_q < DepthCount) begin
              cnt_d = cnt_q + 1'b1;
            end
          end else if (cnt_q == '0) begin
            empty_d = 1'b1;
            state_d = ST_OUT;
          end else begin
            empty_d = 1'b0;
            px_d    = signed'(s_axis_tdata[31:0]);
            py_d    = signed'(s_axis_tdata[63:32]);
            steer_d = 1'b0;
            idx_d   = tgt_q;
            if (yaw_neg > HalfPiQ29) begin
              th_d = yaw_neg - PiQ29;
              flip_d = 1'b1;
            end else if (yaw_neg < -HalfPiQ29) begin
              th_d = yaw_neg + PiQ29;
              flip_d = 1'b1;
            end else begin
              th_d = yaw_neg;
              flip_d = 1'b0;
            end
            state_d = ST_RD;
          end
        end
      end
      ST_RD: state_d = ST_LOAD;
      // form offsets, scale and start the rotation
      ST_LOAD: begin
        dx_d   = dxn;
        dy_d   = dyn;
        cx_d   = flip_q ? -lx : lx;
        cy_d   = flip_q ? -ly : ly;
        cz_d   = th_q;
        iter_d = '0;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        if (!cz_q[AngW-1]) begin
          cx_d = cx_q - ys; cy_d = cy_q + xs; cz_d = cz_q - at;
        end else begin
          cx_d = cx_q + ys; cy_d = cy_q - xs; cz_d = cz_q + at;
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == IterW'(CordicIters - 1)) begin
          state_d = steer_q ? ST_SMUL : ST_VPREP;
        end
      end
      // fold into the right half plane for a one-argument arctangent
      ST_VPREP: begin
        iter_d = '0;
        cz_d   = '0;
        if (cx_q[DataW-1]) begin
          cx_d = -cx_q; cy_d = -cy_q;
        end
        if (cx_q == '0 && cy_q == '0) begin
          lhe_d   = '0;
          state_d = ST_SQX;
        end else begin
          state_d = ST_VEC;
        end
      end
      ST_VEC: begin
        if (!cy_q[DataW-1]) begin
          cx_d = cx_q + ys; cy_d = cy_q - xs; cz_d = cz_q + at;
        end else begin
          cx_d = cx_q - ys; cy_d = cy_q + xs; cz_d = cz_q - at;
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == IterW'(CordicIters - 1)) begin
          if (steer_q) begin
            str_d   = q29_to_q13(cz_d);
            state_d = ST_GRD;
          end else begin
            lhe_d   = q29_to_q13(cz_d);
            state_d = ST_SQX;
          end
        end
      end
      // distance test: coarse compare, then squares
      ST_SQX: begin
        big_d = (ax > 33'(la_q)) || (ay > 33'(la_q));
        mul_a = 32'(ax);
        mul_b = 32'(ax);
        acc_d = DataW'(prod);
        state_d = (big_d) ? ST_CHECK : ST_SQY;
      end
      ST_SQY: begin
        mul_a = 32'(ay);
        mul_b = 32'(ay);
        acc_d = acc_q + DataW'(prod);
        state_d = ST_SQD;
      end
      ST_SQD: begin
        mul_a = 32'(la_q);
        mul_b = 32'(la_q);
        big_d = acc_q > DataW'(prod);
        state_d = ST_CHECK;
      end
      // pick target or advance
      ST_CHECK: begin
        if (big_q && (cz_q < AlphaLimit) && (cz_q > -AlphaLimit)) begin
          tgt_d   = idx_q;
          state_d = ST_SPREP;
        end else if (CntW'(idx_q) + 1'b1 == cnt_q) begin
          state_d = ST_SPREP;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_RD;
        end
      end
      // sine of the heading error
      ST_SPREP: begin
        steer_d = 1'b1;
        cx_d    = InvGainQ30;
        cy_d    = '0;
        cz_d    = AngW'(lhe_q) <<< 16;
        iter_d  = '0;
        state_d = ST_ROT;
      end
      ST_SMUL: begin
        mul_a = cy_q[31:0];
        mul_b = 32'(wb_q);
        cy_d  = DataW'(prod) <<< 1;
        cx_d  = DataW'(la_q) <<< 30;
        state_d = ST_SVPREP;
      end
      ST_SVPREP: begin
        iter_d = '0;
        cz_d   = '0;
        if (cx_q == '0 && cy_q == '0) begin
          str_d   = '0;
          state_d = ST_GRD;
        end else begin
          state_d = ST_VEC;
        end
      end
      ST_GRD: state_d = ST_OUT;
      // load the result once the output register is free
      ST_OUT: begin
        if (!mval_q || m_axis_tready) begin
          mval_d = 1'b1;
          ous_d  = empty_q;
          if (empty_q) begin
            otd_d = '0;
          end else begin
            otd_d = {6'b0, GoalIdxW'(tgt_q), rd_q[63:32], rd_q[31:0], str_q};
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= WB_W'(21299);
      la_q <= LA_W'(65536);
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_WHEELBASE: wb_q <= cfg_data_i[WB_W-1:0];
        REG_LOOKAHEAD: la_q <= cfg_data_i[LA_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      tgt_q   <= '0;
      lhe_q   <= '0;
      mval_q  <= 1'b0;
      steer_q <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tgt_q   <= tgt_d;
      lhe_q   <= lhe_d;
      mval_q  <= mval_d;
      steer_q <= steer_d;
      empty_q <= empty_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    flip_q <= flip_d;
    big_q  <= big_d;
    idx_q  <= idx_d;
    str_q  <= str_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cz_q   <= cz_d;
    th_q   <= th_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    px_q   <= px_d;
    py_q   <= py_d;
    acc_q  <= acc_d;
    otd_q  <= otd_d;
    ous_q  <= ous_d;
  end

endmodule

`default_nettype wire
